// File: sv/nfc_pkg.sv
`default_nettype none
package nfc_pkg;

  localparam int DEF_PASSES      = 5;
  localparam int DEF_LENGTH_BITS = 16;
  localparam int NUM_FORMS       = 42;
  localparam int TOL_BITS        = 10;

  localparam logic [TOL_BITS-1:0] LTOL_RESET  = 10'd102;
  localparam logic [TOL_BITS-1:0] ATOL_RESET  = 10'd20;
  localparam logic [TOL_BITS-1:0] ASTEP_RESET = 10'd20;

  typedef enum logic [1:0] {
    REG_LTOL  = 2'd0,
    REG_ATOL  = 2'd1,
    REG_ASTEP = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_MATCH, ST_PASS_END, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    T_Z, T_A2, T_B2, T_C2, T_HA, T_QA, T_NHA, T_HB, T_NHB, T_BC, T_AC, T_AB,
    T_NBC, T_NAC, T_NAB, T_NTA, T_C6, T_C7, T_C8, T_C16, T_C24, T_HAB, T_HAC,
    T_C43A, T_C43B, T_4BC, T_4AC, T_3A, T_3B, T_CPAC, T_CPBC
  } term_t;

  typedef logic signed [3:0] melem_t;
  typedef melem_t [0:8] mat_t;

  typedef struct packed {
    term_t [0:5]  tgt;
    logic [2:0]   latt;
    logic [2:0]   cent;
    mat_t         m;
    logic [1:0]   extra;
    logic [2:0]   pair;
  } form_t;

  typedef struct packed {
    term_t k1;
    term_t k2;
  } pair_t;

  localparam int NUM_PAIRS = 5;

  localparam pair_t PAIRS [NUM_PAIRS] = '{
    '{T_C2, T_4BC}, '{T_A2, T_4AC}, '{T_B2, T_4BC}, '{T_3A, T_CPAC}, '{T_3B, T_CPBC}
  };

  localparam mat_t PREMUL [2] = '{
    '{0, 0, -1, 0, 1, 0, 1, 0, 1},
    '{-1, 0, -1, 0, 1, 0, 1, 0, 0}
  };

  localparam mat_t ID3 = '{1, 0, 0, 0, 1, 0, 0, 0, 1};

  localparam form_t FORMS [NUM_FORMS] = '{
    '{'{T_A2,T_A2,T_A2,T_HA,T_HA,T_HA},0,3,'{1,-1,1,1,1,-1,-1,1,1},0,0},
    '{'{T_A2,T_A2,T_A2,T_BC,T_BC,T_BC},1,4,'{1,-1,0,-1,0,1,-1,-1,-1},0,0},
    '{'{T_A2,T_A2,T_A2,T_Z,T_Z,T_Z},0,0,'{1,0,0,0,1,0,0,0,1},0,0},
    '{'{T_A2,T_A2,T_A2,T_NBC,T_NBC,T_NBC},1,4,'{1,-1,0,-1,0,1,-1,-1,-1},0,0},
    '{'{T_A2,T_A2,T_A2,T_NTA,T_NTA,T_NTA},0,2,'{1,0,1,1,1,0,0,1,1},0,0},
    '{'{T_A2,T_A2,T_A2,T_C6,T_C6,T_NAB},2,2,'{0,1,1,1,0,1,1,1,0},0,0},
    '{'{T_A2,T_A2,T_A2,T_NBC,T_C7,T_C7},2,2,'{1,0,1,1,1,0,0,1,1},0,0},
    '{'{T_A2,T_A2,T_A2,T_NBC,T_NAC,T_C8},4,2,'{-1,-1,0,-1,0,-1,0,-1,-1},0,0},
    '{'{T_A2,T_A2,T_C2,T_HA,T_HA,T_HA},1,4,'{1,0,0,-1,1,0,-1,-1,3},0,0},
    '{'{T_A2,T_A2,T_C2,T_BC,T_BC,T_AB},5,1,'{1,1,0,1,-1,0,0,0,-1},1,0},
    '{'{T_A2,T_A2,T_C2,T_Z,T_Z,T_Z},2,0,'{1,0,0,0,1,0,0,0,1},0,0},
    '{'{T_A2,T_A2,T_C2,T_Z,T_Z,T_NHA},3,0,'{1,0,0,0,1,0,0,0,1},0,0},
    '{'{T_A2,T_A2,T_C2,T_Z,T_Z,T_NAB},4,1,'{1,1,0,-1,1,0,0,0,1},0,0},
    '{'{T_A2,T_A2,T_C2,T_NBC,T_NBC,T_NAB},5,1,'{1,1,0,-1,1,0,0,0,1},1,0},
    '{'{T_A2,T_A2,T_C2,T_NHA,T_NHA,T_Z},2,2,'{1,0,0,0,1,0,1,1,2},0,0},
    '{'{T_A2,T_A2,T_C2,T_NBC,T_NBC,T_C16},4,3,'{-1,-1,0,1,-1,0,1,1,2},0,0},
    '{'{T_A2,T_A2,T_C2,T_NBC,T_NAC,T_C8},5,2,'{-1,0,-1,-1,-1,0,0,1,1},2,3},
    '{'{T_A2,T_B2,T_B2,T_QA,T_HA,T_HA},2,2,'{0,-1,1,1,-1,-1,1,0,0},0,0},
    '{'{T_A2,T_B2,T_B2,T_BC,T_HA,T_HA},4,2,'{-1,0,0,0,-1,1,-1,1,1},0,0},
    '{'{T_A2,T_B2,T_B2,T_BC,T_AC,T_AC},5,1,'{0,1,1,0,1,-1,-1,0,0},1,1},
    '{'{T_A2,T_B2,T_B2,T_Z,T_Z,T_Z},2,0,'{0,1,0,0,0,1,1,0,0},0,0},
    '{'{T_A2,T_B2,T_B2,T_NHB,T_Z,T_Z},3,0,'{0,1,0,0,0,1,1,0,0},0,0},
    '{'{T_A2,T_B2,T_B2,T_NBC,T_Z,T_Z},4,1,'{0,1,1,0,-1,1,1,0,0},0,0},
    '{'{T_A2,T_B2,T_B2,T_C24,T_NTA,T_NTA},1,4,'{1,2,1,0,-1,1,1,0,0},0,0},
    '{'{T_A2,T_B2,T_B2,T_NBC,T_NAC,T_NAC},5,1,'{0,1,1,0,-1,1,1,0,0},1,1},
    '{'{T_A2,T_B2,T_C2,T_QA,T_HA,T_HA},4,3,'{1,0,0,-1,2,0,-1,0,2},0,0},
    '{'{T_A2,T_B2,T_C2,T_BC,T_HA,T_HA},5,2,'{0,-1,1,-1,0,0,1,-1,-1},2,4},
    '{'{T_A2,T_B2,T_C2,T_HAB,T_HA,T_AB},5,1,'{-1,0,0,-1,0,2,0,1,0},0,0},
    '{'{T_A2,T_B2,T_C2,T_HAC,T_AC,T_HA},5,1,'{1,0,0,1,-2,0,0,0,-1},0,0},
    '{'{T_A2,T_B2,T_C2,T_HB,T_HAB,T_AB},5,1,'{0,1,0,0,1,-2,-1,0,0},0,0},
    '{'{T_A2,T_B2,T_C2,T_Z,T_Z,T_Z},4,0,'{1,0,0,0,1,0,0,0,1},0,0},
    '{'{T_A2,T_B2,T_C2,T_Z,T_NAC,T_Z},5,0,'{1,0,0,0,1,0,0,0,1},0,0},
    '{'{T_A2,T_B2,T_C2,T_Z,T_Z,T_NAB},5,0,'{-1,0,0,0,0,-1,0,-1,0},0,0},
    '{'{T_A2,T_B2,T_C2,T_NBC,T_Z,T_Z},5,0,'{0,-1,0,-1,0,0,0,0,-1},0,0},
    '{'{T_A2,T_B2,T_C2,T_Z,T_NHA,T_Z},4,1,'{1,0,0,-1,0,-2,0,1,0},0,0},
    '{'{T_A2,T_B2,T_C2,T_NBC,T_NHA,T_Z},5,1,'{1,0,2,1,0,0,0,1,0},1,2},
    '{'{T_A2,T_B2,T_C2,T_Z,T_Z,T_NHA},4,1,'{-1,0,0,1,2,0,0,0,-1},0,0},
    '{'{T_A2,T_B2,T_C2,T_NBC,T_Z,T_NHA},5,1,'{-1,-2,0,-1,0,0,0,0,-1},1,0},
    '{'{T_A2,T_B2,T_C2,T_NHB,T_Z,T_Z},4,1,'{0,-1,0,0,1,2,-1,0,0},0,0},
    '{'{T_A2,T_B2,T_C2,T_NHB,T_NAC,T_Z},5,1,'{0,-1,-2,0,-1,0,-1,0,0},1,1},
    '{'{T_A2,T_B2,T_C2,T_NHB,T_NHA,T_Z},4,2,'{-1,0,0,0,-1,0,1,1,2},0,0},
    '{'{T_A2,T_B2,T_C2,T_C43A,T_C43B,T_NAB},5,2,'{-1,0,0,-1,-1,-2,0,-1,0},0,0}
  };

  // premultiply a form matrix by one of the two fixed matrices
  function automatic mat_t premul(input logic [1:0] extra, input mat_t m);
    mat_t r;
    mat_t q;
    int s;
    r = m;
    q = (extra == 2'd2) ? PREMUL[1] : PREMUL[0];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s = 0;
        for (int k = 0; k < 3; k++) begin
          s = s + int'(q[i*3+k]) * int'(m[k*3+j]);
        end
        r[i*3+j] = melem_t'(s);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/nfc_mul.sv
`default_nettype none
module nfc_mul #(
  parameter int XW = 56,
  parameter int YW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [XW-1:0] x,
  input  wire logic [YW-1:0] y,
  output logic               done,
  output logic [XW-1:0]      prod
);

  localparam int CW = $clog2(YW + 1);

  logic [XW-1:0] acc_r, acc_nxt, x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;

  // shift and add, one multiplier bit a cycle
  always_comb begin
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      x_nxt   = x;
      y_nxt   = y;
      cnt_nxt = CW'(YW);
    end else if (cnt_r != '0) begin
      if (y_r[0]) begin
        acc_nxt = acc_r + x_r;
      end
      x_nxt    = x_r << 1;
      y_nxt    = y_r >> 1;
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

// File: sv/nfc_term.sv
`default_nettype none
module nfc_term #(
  parameter int VW = 42
) (
  input  wire nfc_pkg::term_t   code,
  input  wire logic [0:5][VW-1:0] v,
  output logic signed [VW-1:0]  tv
);

  localparam logic signed [VW-1:0] K2  = VW'(2);
  localparam logic signed [VW-1:0] K3  = VW'(3);
  localparam logic signed [VW-1:0] K4  = VW'(4);
  localparam logic signed [VW-1:0] K6  = VW'(6);
  localparam logic signed [VW-1:0] K12 = VW'(12);
  localparam logic signed [VW-1:0] K24 = VW'(24);
  localparam logic signed [VW-1:0] K36 = VW'(36);
  localparam logic signed [VW-1:0] K48 = VW'(48);

  logic signed [VW-1:0] a2, b2, c2, bc, ac, ab, xbc, xac, xab;

  always_comb begin
    a2  = signed'(v[0]);
    b2  = signed'(v[1]);
    c2  = signed'(v[2]);
    bc  = signed'(v[3]);
    ac  = signed'(v[4]);
    ab  = signed'(v[5]);
    xbc = bc[VW-1] ? -bc : bc;
    xac = ac[VW-1] ? -ac : ac;
    xab = ab[VW-1] ? -ab : ab;
    unique case (code)
      nfc_pkg::T_A2:   tv = K12 * a2;
      nfc_pkg::T_B2:   tv = K12 * b2;
      nfc_pkg::T_C2:   tv = K12 * c2;
      nfc_pkg::T_HA:   tv = K6 * a2;
      nfc_pkg::T_QA:   tv = K3 * a2;
      nfc_pkg::T_NHA:  tv = -(K6 * a2);
      nfc_pkg::T_HB:   tv = K6 * b2;
      nfc_pkg::T_NHB:  tv = -(K6 * b2);
      nfc_pkg::T_BC:   tv = K12 * bc;
      nfc_pkg::T_AC:   tv = K12 * ac;
      nfc_pkg::T_AB:   tv = K12 * ab;
      nfc_pkg::T_NBC:  tv = -(K12 * xbc);
      nfc_pkg::T_NAC:  tv = -(K12 * xac);
      nfc_pkg::T_NAB:  tv = -(K12 * xab);
      nfc_pkg::T_NTA:  tv = -(K4 * a2);
      nfc_pkg::T_C6:   tv = K6 * (xab - a2);
      nfc_pkg::T_C7:   tv = K6 * (xbc - a2);
      nfc_pkg::T_C8:   tv = K12 * (xbc + xac - a2);
      nfc_pkg::T_C16:  tv = K12 * (K2 * xbc - a2);
      nfc_pkg::T_C24:  tv = K2 * a2 - K6 * b2;
      nfc_pkg::T_HAB:  tv = K6 * ab;
      nfc_pkg::T_HAC:  tv = K6 * ac;
      nfc_pkg::T_C43A: tv = K6 * (xab - b2);
      nfc_pkg::T_C43B: tv = K6 * (xab - a2);
      nfc_pkg::T_4BC:  tv = K48 * xbc;
      nfc_pkg::T_4AC:  tv = K48 * xac;
      nfc_pkg::T_3A:   tv = K36 * a2;
      nfc_pkg::T_3B:   tv = K36 * b2;
      nfc_pkg::T_CPAC: tv = K12 * c2 + K24 * xac;
      nfc_pkg::T_CPBC: tv = K12 * c2 + K24 * xbc;
      default:         tv = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/niggli_form_classifier.sv
`default_nettype none
// channel  ports                                   dir
// in       in_valid/in_ready, lengths, cosines     in
// out      out_valid/out_ready, class, matrix      out
// cfg      cfg_we, cfg_index, cfg_wdata            in
// one serial multiplier does all products:
// 12 setup products per word, then per pass 8 products and a form walk
// over all 42 forms (one term compare a cycle)
// in_ready is high only when idle; the result is held until out_ready
// synchronous active-low reset restores the register defaults
module niggli_form_classifier #(
  parameter int PASSES      = nfc_pkg::DEF_PASSES,
  parameter int LENGTH_BITS = nfc_pkg::DEF_LENGTH_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [LENGTH_BITS-1:0] in_len_a,
  input  wire logic [LENGTH_BITS-1:0] in_len_b,
  input  wire logic [LENGTH_BITS-1:0] in_len_c,
  input  wire logic signed [15:0]     in_cos_alpha,
  input  wire logic signed [15:0]     in_cos_beta,
  input  wire logic signed [15:0]     in_cos_gamma,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_found,
  output logic [2:0]                  out_lattice_class,
  output logic [2:0]                  out_centring,
  output logic signed [3:0]           out_mat_r0c0,
  output logic signed [3:0]           out_mat_r0c1,
  output logic signed [3:0]           out_mat_r0c2,
  output logic signed [3:0]           out_mat_r1c0,
  output logic signed [3:0]           out_mat_r1c1,
  output logic signed [3:0]           out_mat_r1c2,
  output logic signed [3:0]           out_mat_r2c0,
  output logic signed [3:0]           out_mat_r2c1,
  output logic signed [3:0]           out_mat_r2c2,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [9:0]             cfg_wdata
);

  localparam int L   = LENGTH_BITS;
  localparam int RW  = 2 * L;
  localparam int VW  = 2 * L + 10;
  localparam int PW  = 2 * L + 24;
  localparam int AW  = $clog2(1024 * PASSES);
  localparam int YW  = (L > 17) ? L : 17;
  localparam int PCW = $clog2(PASSES + 1);
  localparam int TW  = nfc_pkg::TOL_BITS;

  localparam logic [4:0] OP_DOT  = 5'd6;
  localparam logic [4:0] OP_LT   = 5'd9;
  localparam logic [4:0] OP_AT   = 5'd12;
  localparam logic [4:0] OP_PR   = 5'd15;
  localparam logic [4:0] OP_LAST = 5'd19;
  localparam logic [5:0] F_LAST  = 6'(nfc_pkg::NUM_FORMS - 1);
  localparam logic signed [VW-1:0] K12 = VW'(12);

  nfc_pkg::state_t state_r, state_nxt;

  logic [TW-1:0] ltol_r, ats_r, astep_r;
  logic [L-1:0]  len_r [3];
  logic [15:0]   cos_r [3];
  logic [RW-1:0] refs_r [6];
  logic signed [VW-1:0] vdot_r [3];
  logic [PW-1:0] lref_r [3];
  logic [PW-1:0] aref_r [3];
  logic [PW-1:0] pref_r [nfc_pkg::NUM_PAIRS];
  logic [AW-1:0] atol_r;
  logic [PCW-1:0] p_r;
  logic [4:0]    op_r;
  logic [5:0]    f_r;
  logic [2:0]    t_r;
  logic          plv_r, bestv_r;
  logic [2:0]    pl_r, pc_r, bestl_r, bestc_r;
  nfc_pkg::mat_t pm_r, bestm_r;

  logic          mul_start, mul_done;
  logic [PW-1:0] mul_x, mul_prod;
  logic [YW-1:0] mul_y;

  logic [0:5][VW-1:0] v_all;
  nfc_pkg::form_t fm;
  nfc_pkg::term_t tcode;
  nfc_pkg::pair_t pr;
  logic [2:0]    psel;
  logic signed [VW-1:0] tv, k1v, k2v, vi, diff, kdiff;
  logic [VW-1:0] k1m, k2m;
  logic [PW-1:0] dmag, kmag, tolp;
  logic          term_ok, prem_ok, rec, upd, next_form;
  logic [4:0]    rel;
  nfc_pkg::mat_t pmat;

  nfc_mul #(.XW(PW), .YW(YW)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .x(mul_x), .y(mul_y),
    .done(mul_done), .prod(mul_prod)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_all[i]   = VW'(refs_r[i]);
      v_all[3+i] = vdot_r[i];
    end
  end

  // term and premultiply compare for the current form
  always_comb begin
    fm    = nfc_pkg::FORMS[f_r];
    tcode = (t_r < 3'd6) ? fm.tgt[t_r] : nfc_pkg::T_Z;
    vi    = (t_r < 3'd6) ? signed'(v_all[t_r]) : '0;
    rel   = op_r - OP_PR;
    psel  = (state_r == nfc_pkg::ST_MATCH) ? fm.pair : rel[2:0];
    pr    = nfc_pkg::PAIRS[psel];
    diff  = K12 * vi - tv;
    dmag  = PW'(diff[VW-1] ? -diff : diff);
    if (t_r < 3'd3) begin
      tolp = lref_r[t_r[1:0]];
    end else begin
      tolp = aref_r[2'(t_r - 3'd3)];
    end
    term_ok = (dmag << 10) <= tolp;
    k1m     = k1v[VW-1] ? -k1v : k1v;
    k2m     = k2v[VW-1] ? -k2v : k2v;
    kdiff   = k1v - k2v;
    kmag    = PW'(kdiff[VW-1] ? -kdiff : kdiff);
    prem_ok = (kmag << 11) < pref_r[fm.pair];
    pmat    = nfc_pkg::premul(fm.extra, fm.m);
    rec     = (t_r == 3'd6) || (t_r == 3'd5 && term_ok && fm.extra == 2'd0);
    upd     = rec && (!plv_r || fm.latt <= pl_r);
    next_form = rec || (t_r < 3'd6 && !term_ok);
  end

  nfc_term #(.VW(VW)) u_term (.code(tcode), .v(v_all), .tv(tv));
  nfc_term #(.VW(VW)) u_k1   (.code(pr.k1), .v(v_all), .tv(k1v));
  nfc_term #(.VW(VW)) u_k2   (.code(pr.k2), .v(v_all), .tv(k2v));

  // multiplier operands by operation
  always_comb begin
    logic [4:0] r;
    logic [PW-1:0] rx;
    mul_x = '0;
    mul_y = '0;
    r     = '0;
    rx    = '0;
    priority if (op_r < OP_DOT) begin
      unique case (op_r[2:0])
        3'd0: begin mul_x = PW'(len_r[0]); mul_y = YW'(len_r[0]); end
        3'd1: begin mul_x = PW'(len_r[1]); mul_y = YW'(len_r[1]); end
        3'd2: begin mul_x = PW'(len_r[2]); mul_y = YW'(len_r[2]); end
        3'd3: begin mul_x = PW'(len_r[1]); mul_y = YW'(len_r[2]); end
        3'd4: begin mul_x = PW'(len_r[0]); mul_y = YW'(len_r[2]); end
        default: begin mul_x = PW'(len_r[0]); mul_y = YW'(len_r[1]); end
      endcase
    end else if (op_r < OP_LT) begin
      r     = op_r - OP_DOT;
      mul_x = PW'(refs_r[3'(r + 5'd3)]);
      mul_y = YW'(cos_r[r[1:0]][15] ? 17'h10000 - {1'b0, cos_r[r[1:0]]}
                                     : {1'b0, cos_r[r[1:0]]});
    end else if (op_r < OP_AT) begin
      r     = op_r - OP_LT;
      rx    = PW'(refs_r[3'(r)]);
      mul_x = (rx << 3) + (rx << 2);
      mul_y = YW'(ltol_r);
    end else if (op_r < OP_PR) begin
      r     = op_r - OP_AT;
      rx    = PW'(refs_r[3'(r + 5'd3)]);
      mul_x = (rx << 3) + (rx << 2);
      mul_y = YW'(atol_r);
    end else begin
      mul_x = PW'(k1m) + PW'(k2m);
      mul_y = YW'(atol_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nfc_pkg::ST_IDLE:     if (in_valid) state_nxt = nfc_pkg::ST_MUL_GO;
      nfc_pkg::ST_MUL_GO:   state_nxt = nfc_pkg::ST_MUL_WAIT;
      nfc_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          state_nxt = (op_r == OP_LAST) ? nfc_pkg::ST_MATCH : nfc_pkg::ST_MUL_GO;
        end
      end
      nfc_pkg::ST_MATCH:    if (next_form && f_r == F_LAST) state_nxt = nfc_pkg::ST_PASS_END;
      nfc_pkg::ST_PASS_END: begin
        state_nxt = (p_r == PCW'(PASSES - 1)) ? nfc_pkg::ST_DONE : nfc_pkg::ST_MUL_GO;
      end
      nfc_pkg::ST_DONE:     if (out_ready) state_nxt = nfc_pkg::ST_IDLE;
      default:              state_nxt = nfc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == nfc_pkg::ST_IDLE);
    out_valid = (state_r == nfc_pkg::ST_DONE);
    mul_start = (state_r == nfc_pkg::ST_MUL_GO);
  end

  always_ff @(posedge clk) begin
    logic [4:0] r;
    logic [PW-1:0] rr;
    r  = op_r - OP_DOT;
    rr = (mul_prod + PW'(14'h2000)) >> 14;
    if (!rst_n) begin
      state_r <= nfc_pkg::ST_IDLE;
      ltol_r  <= nfc_pkg::LTOL_RESET;
      ats_r   <= nfc_pkg::ATOL_RESET;
      astep_r <= nfc_pkg::ASTEP_RESET;
      op_r    <= '0;
      p_r     <= '0;
      f_r     <= '0;
      t_r     <= '0;
      plv_r   <= 1'b0;
      bestv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (nfc_pkg::reg_idx_t'(cfg_index))
          nfc_pkg::REG_LTOL:  ltol_r  <= cfg_wdata;
          nfc_pkg::REG_ATOL:  ats_r   <= cfg_wdata;
          nfc_pkg::REG_ASTEP: astep_r <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        nfc_pkg::ST_IDLE: begin
          if (in_valid) begin
            len_r[0] <= in_len_a;
            len_r[1] <= in_len_b;
            len_r[2] <= in_len_c;
            cos_r[0] <= in_cos_alpha;
            cos_r[1] <= in_cos_beta;
            cos_r[2] <= in_cos_gamma;
            op_r     <= '0;
            p_r      <= '0;
            f_r      <= '0;
            t_r      <= '0;
            atol_r   <= AW'(ats_r);
            plv_r    <= 1'b0;
            bestv_r  <= 1'b0;
            bestl_r  <= '0;
            bestc_r  <= '0;
            bestm_r  <= nfc_pkg::ID3;
          end
        end
        nfc_pkg::ST_MUL_WAIT: begin
          if (mul_done) begin
            priority if (op_r < OP_DOT) begin
              refs_r[op_r[2:0]] <= RW'(mul_prod);
            end else if (op_r < OP_LT) begin
              vdot_r[r[1:0]] <= cos_r[r[1:0]][15] ? -VW'(rr) : VW'(rr);
            end else if (op_r < OP_AT) begin
              lref_r[2'(op_r - OP_LT)] <= mul_prod;
            end else if (op_r < OP_PR) begin
              aref_r[2'(op_r - OP_AT)] <= mul_prod;
            end else begin
              pref_r[3'(op_r - OP_PR)] <= mul_prod;
            end
            op_r <= op_r + 1'b1;
          end
        end
        nfc_pkg::ST_MATCH: begin
          if (upd) begin
            plv_r <= 1'b1;
            pl_r  <= fm.latt;
            pc_r  <= fm.cent;
            pm_r  <= (t_r == 3'd6 && prem_ok) ? pmat : fm.m;
          end
          if (next_form) begin
            t_r <= '0;
            f_r <= f_r + 1'b1;
          end else begin
            t_r <= (t_r == 3'd5) ? 3'd6 : t_r + 1'b1;
          end
        end
        nfc_pkg::ST_PASS_END: begin
          if (plv_r && (!bestv_r || pl_r < bestl_r)) begin
            bestv_r <= 1'b1;
            bestl_r <= pl_r;
            bestc_r <= pc_r;
            bestm_r <= pm_r;
          end
          p_r    <= p_r + 1'b1;
          atol_r <= atol_r + AW'(astep_r);
          op_r   <= OP_AT;
          f_r    <= '0;
          t_r    <= '0;
          plv_r  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_found         = bestv_r;
  assign out_lattice_class = bestv_r ? bestl_r : 3'd0;
  assign out_centring      = bestv_r ? bestc_r : 3'd0;
  assign out_mat_r0c0 = bestm_r[0];
  assign out_mat_r0c1 = bestm_r[1];
  assign out_mat_r0c2 = bestm_r[2];
  assign out_mat_r1c0 = bestm_r[3];
  assign out_mat_r1c1 = bestm_r[4];
  assign out_mat_r1c2 = bestm_r[5];
  assign out_mat_r2c0 = bestm_r[6];
  assign out_mat_r2c1 = bestm_r[7];
  assign out_mat_r2c2 = bestm_r[8];

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_form_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfc_pkg::ST_MATCH) |-> (f_r <= F_LAST && t_r <= 3'd6))
    else $error("form walk out of range");
  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfc_pkg::ST_PASS_END) |-> ($past(f_r) == F_LAST))
    else $error("pass ended early");
  a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_lattice_class == 3'd0 && out_centring == 3'd0))
    else $error("class without match");

endmodule
`default_nettype wire

// File: test/tb_niggli_form_classifier.sv
`timescale 1ns / 1ps
module tb_niggli_form_classifier;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int RAND_CELLS     = 1800;
  localparam int N_PHASES       = 6;
  localparam int PASSES_TB      = nfc_pkg::DEF_PASSES;

  typedef struct {
    logic [15:0]        a, b, c;
    logic signed [15:0] ca, cb, cg;
  } cell_t;

  typedef struct packed {
    logic          found;
    logic [2:0]    latt;
    logic [2:0]    cent;
    nfc_pkg::mat_t m;
  } conv_t;

  typedef struct {
    cell_t geom;
    bit    typed;
    conv_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_len_a = '0, in_len_b = '0, in_len_c = '0;
  logic signed [15:0] in_cos_alpha = '0, in_cos_beta = '0, in_cos_gamma = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  logic [2:0] out_lattice_class, out_centring;
  logic signed [3:0] out_mat_r0c0, out_mat_r0c1, out_mat_r0c2;
  logic signed [3:0] out_mat_r1c0, out_mat_r1c1, out_mat_r1c2;
  logic signed [3:0] out_mat_r2c0, out_mat_r2c1, out_mat_r2c2;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [9:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  niggli_form_classifier u_dut (.*);

  // register mirror
  logic [9:0] len_tol, ang_tol0, ang_step;

  conv_t expected_cells[$];
  int    errors = 0;
  int    n_results = 0;
  int    n_found = 0;
  int    class_hits[6];
  bit    quiet = 1'b0;
  bit    idling_on = 1'b1;
  bit    hold_req = 1'b0;
  int    stall_cnt = 0;

  // ---------------- predictor ----------------

  function automatic longint term_val(nfc_pkg::term_t t, longint v[6]);
    longint a2, b2, c2, xbc, xac, xab;
    a2 = v[0]; b2 = v[1]; c2 = v[2];
    xbc = v[3] < 0 ? -v[3] : v[3];
    xac = v[4] < 0 ? -v[4] : v[4];
    xab = v[5] < 0 ? -v[5] : v[5];
    case (t)
      nfc_pkg::T_A2:   return 12 * a2;
      nfc_pkg::T_B2:   return 12 * b2;
      nfc_pkg::T_C2:   return 12 * c2;
      nfc_pkg::T_HA:   return 6 * a2;
      nfc_pkg::T_QA:   return 3 * a2;
      nfc_pkg::T_NHA:  return -6 * a2;
      nfc_pkg::T_HB:   return 6 * b2;
      nfc_pkg::T_NHB:  return -6 * b2;
      nfc_pkg::T_BC:   return 12 * v[3];
      nfc_pkg::T_AC:   return 12 * v[4];
      nfc_pkg::T_AB:   return 12 * v[5];
      nfc_pkg::T_NBC:  return -12 * xbc;
      nfc_pkg::T_NAC:  return -12 * xac;
      nfc_pkg::T_NAB:  return -12 * xab;
      nfc_pkg::T_NTA:  return -4 * a2;
      nfc_pkg::T_C6:   return 6 * (xab - a2);
      nfc_pkg::T_C7:   return 6 * (xbc - a2);
      nfc_pkg::T_C8:   return -12 * (a2 - xbc - xac);
      nfc_pkg::T_C16:  return -12 * (a2 - 2 * xbc);
      nfc_pkg::T_C24:  return 2 * a2 - 6 * b2;
      nfc_pkg::T_HAB:  return 6 * v[5];
      nfc_pkg::T_HAC:  return 6 * v[4];
      nfc_pkg::T_C43A: return -6 * (b2 - xab);
      nfc_pkg::T_C43B: return -6 * (a2 - xab);
      nfc_pkg::T_4BC:  return 48 * xbc;
      nfc_pkg::T_4AC:  return 48 * xac;
      nfc_pkg::T_3A:   return 36 * a2;
      nfc_pkg::T_3B:   return 36 * b2;
      nfc_pkg::T_CPAC: return 12 * c2 + 24 * xac;
      nfc_pkg::T_CPBC: return 12 * c2 + 24 * xbc;
      default: return 0;
    endcase
  endfunction

  function automatic logic [127:0] absw(longint x);
    logic [127:0] r;
    r = x < 0 ? 128'(-x) : 128'(x);
    return r;
  endfunction

  // b*c*cos / 2^14, rounded half away from zero
  function automatic longint scaled_dot(longint unsigned p, logic [15:0] cr);
    logic [16:0] cm;
    logic [127:0] r;
    cm = cr[15] ? (17'h10000 - {1'b0, cr}) : {1'b0, cr};
    r = (128'(p) * 128'(cm) + 128'h2000) >> 14;
    return cr[15] ? -longint'(r) : longint'(r);
  endfunction

  function automatic conv_t classify(cell_t cl);
    longint unsigned refs[6];
    longint v[6];
    conv_t best, cur;
    int pl, best_l;
    logic [127:0] atol, tolv, d;
    bit ok;
    longint k1, k2;
    nfc_pkg::mat_t q, pm;
    int s;
    refs[0] = longint'(cl.a) * cl.a;
    refs[1] = longint'(cl.b) * cl.b;
    refs[2] = longint'(cl.c) * cl.c;
    refs[3] = longint'(cl.b) * cl.c;
    refs[4] = longint'(cl.a) * cl.c;
    refs[5] = longint'(cl.a) * cl.b;
    for (int i = 0; i < 3; i++) v[i] = longint'(refs[i]);
    v[3] = scaled_dot(refs[3], cl.ca);
    v[4] = scaled_dot(refs[4], cl.cb);
    v[5] = scaled_dot(refs[5], cl.cg);
    best = '0;
    best.m = nfc_pkg::ID3;
    best_l = -1;
    for (int p = 0; p < PASSES_TB; p++) begin
      atol = 128'(ang_tol0) + 128'(p) * 128'(ang_step);
      pl = -1;
      cur = '0;
      for (int f = 0; f < nfc_pkg::NUM_FORMS; f++) begin
        ok = 1'b1;
        for (int i = 0; i < 6 && ok; i++) begin
          d = absw(12 * v[i] - term_val(nfc_pkg::FORMS[f].tgt[i], v));
          tolv = i < 3 ? 128'(len_tol) : atol;
          ok = d * 1024 <= tolv * 12 * 128'(refs[i]);
        end
        if (!ok) continue;
        if (pl >= 0 && pl < int'(nfc_pkg::FORMS[f].latt)) continue;
        pl = nfc_pkg::FORMS[f].latt;
        cur.latt = nfc_pkg::FORMS[f].latt;
        cur.cent = nfc_pkg::FORMS[f].cent;
        cur.m = nfc_pkg::FORMS[f].m;
        if (nfc_pkg::FORMS[f].extra != 2'd0) begin
          k1 = term_val(nfc_pkg::PAIRS[nfc_pkg::FORMS[f].pair].k1, v);
          k2 = term_val(nfc_pkg::PAIRS[nfc_pkg::FORMS[f].pair].k2, v);
          if (absw(k1 - k2) * 2048 < atol * (absw(k1) + absw(k2))) begin
            q = nfc_pkg::PREMUL[nfc_pkg::FORMS[f].extra - 1];
            for (int i = 0; i < 3; i++)
              for (int j = 0; j < 3; j++) begin
                s = 0;
                for (int k = 0; k < 3; k++)
                  s += int'(q[i*3+k]) * int'(nfc_pkg::FORMS[f].m[k*3+j]);
                pm[i*3+j] = nfc_pkg::melem_t'(s);
              end
            cur.m = pm;
          end
        end
      end
      if (pl >= 0 && (best_l < 0 || pl < best_l)) begin
        best_l = pl;
        best = cur;
        best.found = 1'b1;
      end
    end
    return best;
  endfunction

  // ---------------- stimulus shaping ----------------

  function automatic logic signed [15:0] cos_for(longint dot, longint unsigned x,
                                                 longint unsigned y);
    real r;
    longint c;
    if (x == 0 || y == 0) return 16'sd0;
    r = real'(dot) * 16384.0 / (real'(x) * real'(y));
    c = longint'(r) + longint'($urandom_range(0, 4)) - 2;
    if ($urandom_range(3) == 0) c = longint'(r);
    if (c > 16384) c = 16384;
    if (c < -16384) c = -16384;
    return 16'(c);
  endfunction

  // a reduced cell built to sit on or near one of the listed forms
  function automatic cell_t form_cell();
    cell_t cl;
    int f;
    longint unsigned la, lb, lc;
    longint v[6];
    f = $urandom_range(nfc_pkg::NUM_FORMS - 1);
    la = $urandom_range(0, 15) == 0 ? $urandom_range(1, 65535) : $urandom_range(64, 6000);
    lb = nfc_pkg::FORMS[f].tgt[1] == nfc_pkg::T_A2 ? la : la + $urandom_range(0, 3000);
    lc = nfc_pkg::FORMS[f].tgt[2] == nfc_pkg::T_A2 ? la :
         nfc_pkg::FORMS[f].tgt[2] == nfc_pkg::T_B2 ? lb : lb + $urandom_range(0, 3000);
    if (lb > 65535) lb = 65535;
    if (lc > 65535) lc = 65535;
    v[0] = la * la; v[1] = lb * lb; v[2] = lc * lc;
    v[3] = (longint'(lb * lc) * (longint'($urandom_range(0, 8000)) - 4000)) / 16384;
    v[4] = (longint'(la * lc) * (longint'($urandom_range(0, 8000)) - 4000)) / 16384;
    v[5] = (longint'(la * lb) * (longint'($urandom_range(0, 8000)) - 4000)) / 16384;
    for (int it = 0; it < 3; it++)
      for (int i = 3; i < 6; i++) v[i] = term_val(nfc_pkg::FORMS[f].tgt[i], v) / 12;
    cl.a = 16'(la); cl.b = 16'(lb); cl.c = 16'(lc);
    cl.ca = cos_for(v[3], lb, lc);
    cl.cb = cos_for(v[4], la, lc);
    cl.cg = cos_for(v[5], la, lb);
    return cl;
  endfunction

  function automatic cell_t noise_cell();
    cell_t cl;
    cl.a = 16'($urandom_range(0, 65535));
    cl.b = $urandom_range(3) == 0 ? cl.a : 16'($urandom_range(0, 65535));
    cl.c = $urandom_range(3) == 0 ? cl.b : 16'($urandom_range(0, 65535));
    cl.ca = 16'($urandom_range(0, 32768) - 16384);
    cl.cb = 16'($urandom_range(0, 32768) - 16384);
    cl.cg = 16'($urandom_range(0, 32768) - 16384);
    return cl;
  endfunction

  function automatic cell_t mk(int a, int b, int c, int ca, int cb, int cg);
    cell_t cl;
    cl.a = 16'(a); cl.b = 16'(b); cl.c = 16'(c);
    cl.ca = 16'(ca); cl.cb = 16'(cb); cl.cg = 16'(cg);
    return cl;
  endfunction

  function automatic conv_t mkres(int latt, int cent, nfc_pkg::mat_t m);
    conv_t r;
    r.found = 1'b1; r.latt = 3'(latt); r.cent = 3'(cent); r.m = m;
    return r;
  endfunction

  // ---------------- driving ----------------

  task automatic send_cell(cell_t cl, bit typed, conv_t typed_res);
    if (!quiet && idling_on && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_len_a     <= cl.a;
    in_len_b     <= cl.b;
    in_len_c     <= cl.c;
    in_cos_alpha <= cl.ca;
    in_cos_beta  <= cl.cb;
    in_cos_gamma <= cl.cg;
    do @(posedge clk); while (!in_ready);
    expected_cells.push_back(typed ? typed_res : classify(cl));
  endtask

  task automatic write_regs(logic [9:0] lt, logic [9:0] a0, logic [9:0] as);
    in_valid <= 1'b0;
    wait (expected_cells.size() == 0);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= nfc_pkg::REG_LTOL;  cfg_wdata <= lt; @(posedge clk);
    cfg_index <= nfc_pkg::REG_ATOL;  cfg_wdata <= a0; @(posedge clk);
    cfg_index <= nfc_pkg::REG_ASTEP; cfg_wdata <= as; @(posedge clk);
    // out-of-range index must leave everything alone
    cfg_index <= nfc_pkg::REG_NONE;  cfg_wdata <= 10'($urandom); @(posedge clk);
    cfg_we <= 1'b0;
    len_tol = lt; ang_tol0 = a0; ang_step = as;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && idling_on && $urandom_range(3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result check
  always @(posedge clk) begin
    conv_t want, got;
    if (rst_n && out_valid && out_ready) begin
      got.found = out_found;
      got.latt  = out_lattice_class;
      got.cent  = out_centring;
      got.m = '{out_mat_r0c0, out_mat_r0c1, out_mat_r0c2, out_mat_r1c0, out_mat_r1c1,
                out_mat_r1c2, out_mat_r2c0, out_mat_r2c1, out_mat_r2c2};
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected word: found=%0d class=%0d", $time, got.found, got.latt);
        errors++;
      end else begin
        want = expected_cells.pop_front();
        n_results++;
        if (want.found) begin
          n_found++;
          if (want.latt < 6) class_hits[want.latt]++;
        end
        if (got.found !== want.found || got.latt !== want.latt || got.cent !== want.cent) begin
          $display("%0t: found/class/centring expected %0d/%0d/%0d actual %0d/%0d/%0d",
                   $time, want.found, want.latt, want.cent, got.found, got.latt, got.cent);
          errors++;
        end
        for (int i = 0; i < 9; i++)
          if (got.m[i] !== want.m[i]) begin
            $display("%0t: matrix element %0d expected %0d actual %0d",
                     $time, i, want.m[i], got.m[i]);
            errors++;
          end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows[13];
    logic [9:0] phase_lt[N_PHASES];
    logic [9:0] phase_a0[N_PHASES];
    logic [9:0] phase_as[N_PHASES];
    conv_t none;
    int per_phase;
    phase_lt = '{102, 0, 1023, 102, 0, 200};
    phase_a0 = '{20, 0, 1023, 1, 0, 50};
    phase_as = '{20, 0, 1023, 300, 0, 0};
    none = '0;
    len_tol = nfc_pkg::LTOL_RESET;
    ang_tol0 = nfc_pkg::ATOL_RESET;
    ang_step = nfc_pkg::ASTEP_RESET;

    // directed cells; only trivially readable answers are typed in
    dir_rows[0]  = '{mk(0, 0, 0, 0, 0, 0), 1, mkres(0, 3'd2, '{1,0,1,1,1,0,0,1,1})};
    dir_rows[1]  = '{mk(256, 256, 256, 0, 0, 0), 1, mkres(0, 3'd0, nfc_pkg::ID3)};
    dir_rows[2]  = '{mk(65535, 65535, 65535, 16384, 16384, 16384), 1,
                     mkres(1, 3'd4, '{1,-1,0,-1,0,1,-1,-1,-1})};
    dir_rows[3]  = '{mk(65535, 65535, 65535, -16384, -16384, -16384), 0, none};
    dir_rows[4]  = '{mk(1000, 1000, 3000, 0, 0, -8192), 0, none};
    dir_rows[5]  = '{mk(1000, 2000, 2000, 0, 0, 0), 0, none};
    dir_rows[6]  = '{mk(1000, 2000, 3000, 0, 0, 0), 0, none};
    dir_rows[7]  = '{mk(1000, 2000, 3000, 0, -3000, 0), 0, none};
    dir_rows[8]  = '{mk(1000, 1000, 1000, 8192, 8192, 8192), 0, none};
    dir_rows[9]  = '{mk(1000, 1000, 1000, -5461, -5461, -5461), 0, none};
    dir_rows[10] = '{mk(1, 65535, 0, 16384, -16384, 1), 0, none};
    dir_rows[11] = '{mk(65535, 1, 32768, -1, 16383, -16383), 0, none};
    dir_rows[12] = '{mk(1200, 1500, 2100, 5000, -7000, 3000), 0, none};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_cell(dir_rows[i].geom, dir_rows[i].typed, dir_rows[i].res);

    per_phase = RAND_CELLS / N_PHASES;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) write_regs(phase_lt[ph], phase_a0[ph], phase_as[ph]);
      else write_regs(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 60)),
                      10'($urandom_range(0, 60)));
      for (int n = 0; n < per_phase; n++) begin
        if (n % 40 == 0) idling_on = $urandom_range(2) != 0;
        if (ph == 1 && n == 20) hold_req = 1'b1;
        if (ph == N_PHASES - 1 && n >= per_phase * 3 / 4) quiet = 1'b1;
        send_cell($urandom_range(9) < 7 ? form_cell() : noise_cell(), 0, none);
      end
    end
    in_valid <= 1'b0;

    wait (expected_cells.size() == 0);
    repeat (100) @(posedge clk);
    $display("classified %0d cells under %0d tolerance settings, %0d matched a form",
             n_results, N_PHASES + 1, n_found);
    $display("matches by class: cub %0d rh %0d tet %0d hex %0d ort %0d mono %0d",
             class_hits[0], class_hits[1], class_hits[2], class_hits[3],
             class_hits[4], class_hits[5]);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
